// ===== hdl/rtts_pkg.sv =====
// shared types, constants and helpers for the range top-two sum table
`default_nettype none

package rtts_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int BLOCK_SIZE_DEF  = 32;

  localparam int IDX_W = 11;
  localparam int VAL_W = 27;
  localparam int SUM_W = 28;

  localparam logic [IDX_W-1:0] LEN_RESET = 11'd1024;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PLAN,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } pair_t;

  function automatic pair_t pair_insert(input pair_t p, input logic [VAL_W-1:0] v);
    pair_t r;
    r = p;
    if (p.first < v) begin
      r.second = p.first;
      r.first  = v;
    end else if (p.second < v) begin
      r.second = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/range_top_two_sum_table_unit.sv =====
// range top-two sum table: element store, per-block top-two summaries and scan sequencer
//
// Input channel (in_*): one transfer per command. An update (opcode 0) writes one
// entry and rescans its block; an update outside 1..sequence_length is dropped and
// returns nothing. A query (opcode 1) returns one transfer on the result channel
// (out_*): the largest sum of two distinct entries in [range_first, range_last], or
// status 1 and sum 0 for an empty, single-entry, reversed or out-of-length range.
// Items are handled one at a time; in_stall is high while an item is in progress.
// With B = BLOCK_SIZE, an update rescans the entries of its block. A query reads n
// items, n being the entries in the partial end blocks plus the whole blocks between
// them (at most 2*B + TABLE_DEPTH/B - 2). Each memory has a single read port, read at
// one entry or summary per cycle, and each bound goes through a block index split.
// After reset the block runs a clearing pass that zeroes both memories; in_stall
// stays high during it. cfg_wr_en writes sequence_length at any time (reset value
// 1024). A finished result sits in the output register; the next item is taken
// while it waits, and a later result waits until out_stall drops.
`default_nettype none

module range_top_two_sum_table_unit #(
  parameter int TABLE_DEPTH = rtts_pkg::TABLE_DEPTH_DEF,
  parameter int BLOCK_SIZE  = rtts_pkg::BLOCK_SIZE_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [rtts_pkg::IDX_W-1:0]    cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_opcode,
  input  wire [rtts_pkg::IDX_W-1:0]    in_update_index,
  input  wire [rtts_pkg::VAL_W-1:0]    in_update_value,
  input  wire [rtts_pkg::IDX_W-1:0]    in_range_first,
  input  wire [rtts_pkg::IDX_W-1:0]    in_range_last,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [rtts_pkg::SUM_W-1:0]   out_pair_sum,
  output logic                         out_status
);

  localparam int IW          = $clog2(TABLE_DEPTH);
  localparam int LW          = (IW + 1 > rtts_pkg::IDX_W) ? IW + 1 : rtts_pkg::IDX_W;
  localparam int BLOCK_COUNT = (TABLE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BW          = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int DW          = IW + 8;
  localparam int CW          = $clog2(IW);

  // reciprocal of the block size, exact for every index below 2**IW
  localparam int SH = IW + $clog2(BLOCK_SIZE);
  localparam int PW = SH + IW;
  localparam int RM = ((1 << SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;

  // memories
  logic [rtts_pkg::VAL_W-1:0] el_mem [TABLE_DEPTH];
  rtts_pkg::pair_t            sm_mem [BLOCK_COUNT];

  logic                       el_we, el_re;
  logic [IW-1:0]              el_wa, el_ra;
  logic [rtts_pkg::VAL_W-1:0] el_wd;
  logic                       sm_we, sm_re;
  logic [BW-1:0]              sm_wa, sm_ra;
  rtts_pkg::pair_t            sm_wd;

  logic [rtts_pkg::VAL_W-1:0] el_q_r;
  rtts_pkg::pair_t            sm_q_r;
  logic                       el_vld_r, sm_vld_r;

  // control and datapath registers
  rtts_pkg::state_t           state_r, state_nxt;
  logic [IW-1:0]              clr_r, clr_nxt;
  logic [rtts_pkg::IDX_W-1:0] cfg_len_r;
  logic                       upd_r, upd_nxt;
  logic                       err_r, err_nxt;
  logic [IW-1:0]              p0_r, p0_nxt;
  logic [IW-1:0]              p1_r, p1_nxt;
  logic [IW-1:0]              rem_r, rem_nxt;
  logic [IW-1:0]              q_r, q_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       pass_r, pass_nxt;
  logic [BW-1:0]              b0_r, b0_nxt;
  logic [IW-1:0]              r0_r, r0_nxt;
  logic [IW-1:0]              cur_r, cur_nxt;
  logic [IW-1:0]              lim_r, lim_nxt;
  logic [BW-1:0]              bcur_r, bcur_nxt;
  logic [BW-1:0]              blim_r, blim_nxt;
  logic                       same_r, same_nxt;
  logic                       mid_r, mid_nxt;
  logic [IW-1:0]              cst_r, cst_nxt;
  rtts_pkg::pair_t            acc_r, acc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [rtts_pkg::SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                       out_status_r, out_status_nxt;

  // decode of the incoming item
  logic [LW-1:0] len_eff;
  logic [LW-1:0] upd_idx_x, first_x, last_x;
  logic [LW-1:0] upd_pm, first_m, last_m;
  logic [IW-1:0] upd_p, qp0, qp1;
  logic          upd_ok, qry_bad;

  assign len_eff   = (LW'(cfg_len_r) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(cfg_len_r);
  assign upd_idx_x = LW'(in_update_index);
  assign first_x   = LW'(in_range_first);
  assign last_x    = LW'(in_range_last);
  assign upd_pm    = upd_idx_x - LW'(1);
  assign first_m   = first_x - LW'(1);
  assign last_m    = last_x - LW'(1);
  assign upd_p     = upd_pm[IW-1:0];
  assign qp0       = first_m[IW-1:0];
  assign qp1       = last_m[IW-1:0];
  assign upd_ok    = (upd_idx_x != '0) && (upd_idx_x <= len_eff);
  assign qry_bad   = (first_x == '0) || (last_x > len_eff) || (first_x >= last_x);

  // block index split and scan bounds
  logic [PW-1:0] div_prod;
  logic [DW-1:0] blk_base_w;
  logic [IW-1:0] upd_s, upd_end;
  logic [DW-1:0] upd_end_w, a_end_w;
  logic [BW-1:0] qb1;
  logic [BW:0]   b0_inc;

  assign div_prod   = PW'(rem_r) * PW'(RM);
  assign blk_base_w = DW'(q_r) * DW'(BLOCK_SIZE);
  assign upd_s      = p0_r - rem_r;
  assign upd_end_w  = DW'(upd_s) + DW'(BLOCK_SIZE - 1);
  assign upd_end    = (upd_end_w > DW'(TABLE_DEPTH - 1)) ? IW'(TABLE_DEPTH - 1)
                                                         : upd_end_w[IW-1:0];
  assign a_end_w    = DW'(p0_r) + DW'(BLOCK_SIZE - 1) - DW'(r0_r);
  assign qb1        = q_r[BW-1:0];
  assign b0_inc     = {1'b0, b0_r} + (BW+1)'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    upd_nxt        = upd_r;
    err_nxt        = err_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    pass_nxt       = pass_r;
    b0_nxt         = b0_r;
    r0_nxt         = r0_r;
    cur_nxt        = cur_r;
    lim_nxt        = lim_r;
    bcur_nxt       = bcur_r;
    blim_nxt       = blim_r;
    same_nxt       = same_r;
    mid_nxt        = mid_r;
    cst_nxt        = cst_r;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    in_stall       = 1'b1;
    el_we          = 1'b0;
    el_wa          = clr_r;
    el_wd          = '0;
    el_re          = 1'b0;
    el_ra          = cur_r;
    sm_we          = 1'b0;
    sm_wa          = clr_r[BW-1:0];
    sm_wd          = '0;
    sm_re          = 1'b0;
    sm_ra          = bcur_r;

    if (el_vld_r) begin
      acc_nxt = rtts_pkg::pair_insert(acc_r, el_q_r);
    end else if (sm_vld_r) begin
      acc_nxt = rtts_pkg::pair_insert(rtts_pkg::pair_insert(acc_r, sm_q_r.first),
                                      sm_q_r.second);
    end else begin
      acc_nxt = acc_r;
    end

    case (state_r)
      rtts_pkg::ST_CLEAR: begin
        el_we = 1'b1;
        sm_we = {1'b0, clr_r} < (IW+1)'(BLOCK_COUNT);
        if (clr_r == IW'(TABLE_DEPTH - 1)) begin
          state_nxt = rtts_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      rtts_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          acc_nxt  = '0;
          err_nxt  = 1'b0;
          rem_nxt  = qp0;
          q_nxt    = '0;
          cnt_nxt  = '0;
          pass_nxt = 1'b0;
          p0_nxt   = qp0;
          p1_nxt   = qp1;
          if (in_opcode == rtts_pkg::OP_UPDATE) begin
            upd_nxt = 1'b1;
            p0_nxt  = upd_p;
            rem_nxt = upd_p;
            if (upd_ok) begin
              el_we     = 1'b1;
              el_wa     = upd_p;
              el_wd     = in_update_value;
              state_nxt = rtts_pkg::ST_DIV;
            end
          end else begin
            upd_nxt = 1'b0;
            if (qry_bad) begin
              err_nxt   = 1'b1;
              state_nxt = rtts_pkg::ST_FIN;
            end else begin
              state_nxt = rtts_pkg::ST_DIV;
            end
          end
        end
      end
      rtts_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          q_nxt = div_prod[PW-1:SH];
        end else begin
          rem_nxt   = rem_r - blk_base_w[IW-1:0];
          state_nxt = rtts_pkg::ST_PLAN;
        end
      end
      rtts_pkg::ST_PLAN: begin
        if (upd_r) begin
          b0_nxt    = qb1;
          cur_nxt   = upd_s;
          lim_nxt   = upd_end;
          same_nxt  = 1'b1;
          state_nxt = rtts_pkg::ST_SCAN_A;
        end else if (!pass_r) begin
          b0_nxt    = qb1;
          r0_nxt    = rem_r;
          rem_nxt   = p1_r;
          q_nxt     = '0;
          cnt_nxt   = '0;
          pass_nxt  = 1'b1;
          state_nxt = rtts_pkg::ST_DIV;
        end else begin
          same_nxt  = qb1 == b0_r;
          mid_nxt   = {1'b0, qb1} > b0_inc;
          cur_nxt   = p0_r;
          lim_nxt   = (qb1 == b0_r) ? p1_r : a_end_w[IW-1:0];
          bcur_nxt  = b0_inc[BW-1:0];
          blim_nxt  = qb1 - BW'(1);
          cst_nxt   = p1_r - rem_r;
          state_nxt = rtts_pkg::ST_SCAN_A;
        end
      end
      rtts_pkg::ST_SCAN_A: begin
        el_re   = 1'b1;
        cur_nxt = cur_r + IW'(1);
        if (cur_r == lim_r) begin
          if (same_r) begin
            state_nxt = rtts_pkg::ST_DRAIN;
          end else if (mid_r) begin
            state_nxt = rtts_pkg::ST_SCAN_B;
          end else begin
            cur_nxt   = cst_r;
            lim_nxt   = p1_r;
            state_nxt = rtts_pkg::ST_SCAN_C;
          end
        end
      end
      rtts_pkg::ST_SCAN_B: begin
        sm_re    = 1'b1;
        bcur_nxt = bcur_r + BW'(1);
        if (bcur_r == blim_r) begin
          cur_nxt   = cst_r;
          lim_nxt   = p1_r;
          state_nxt = rtts_pkg::ST_SCAN_C;
        end
      end
      rtts_pkg::ST_SCAN_C: begin
        el_re   = 1'b1;
        cur_nxt = cur_r + IW'(1);
        if (cur_r == lim_r) begin
          state_nxt = rtts_pkg::ST_DRAIN;
        end
      end
      rtts_pkg::ST_DRAIN: begin
        state_nxt = rtts_pkg::ST_FIN;
      end
      rtts_pkg::ST_FIN: begin
        if (upd_r) begin
          sm_we     = 1'b1;
          sm_wa     = b0_r;
          sm_wd     = acc_r;
          state_nxt = rtts_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sum_nxt    = err_r ? '0 : rtts_pkg::SUM_W'(acc_r.first)
                                        + rtts_pkg::SUM_W'(acc_r.second);
          out_status_nxt = err_r ? rtts_pkg::STATUS_BAD : rtts_pkg::STATUS_OK;
          state_nxt      = rtts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rtts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (el_we) begin
      el_mem[el_wa] <= el_wd;
    end
    if (el_re) begin
      el_q_r <= el_mem[el_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_wa] <= sm_wd;
    end
    if (sm_re) begin
      sm_q_r <= sm_mem[sm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtts_pkg::ST_CLEAR;
      clr_r       <= '0;
      cfg_len_r   <= rtts_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
      el_vld_r    <= 1'b0;
      sm_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      el_vld_r    <= el_re;
      sm_vld_r    <= sm_re;
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_r        <= upd_nxt;
    err_r        <= err_nxt;
    p0_r         <= p0_nxt;
    p1_r         <= p1_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    pass_r       <= pass_nxt;
    b0_r         <= b0_nxt;
    r0_r         <= r0_nxt;
    cur_r        <= cur_nxt;
    lim_r        <= lim_nxt;
    bcur_r       <= bcur_nxt;
    blim_r       <= blim_nxt;
    same_r       <= same_nxt;
    mid_r        <= mid_nxt;
    cst_r        <= cst_nxt;
    acc_r        <= acc_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pair_sum = out_sum_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

// ===== sim/range_top_two_sum_table_unit_test.sv =====
// testbench for range_top_two_sum_table_unit: directed table, then checked random traffic
module range_top_two_sum_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rtts_pkg::TABLE_DEPTH_DEF;
  localparam int HALF_PERIOD = 6;
  localparam int SETTLE = 160;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 7;
  localparam int unsigned VALUE_LIMIT = 100000000;
  localparam int unsigned VALUE_TOP = 32'h07FF_FFFF;
  localparam int unsigned SUM_TOP = 2 * VALUE_TOP;

  typedef struct packed {
    logic                      op;
    logic [rtts_pkg::IDX_W-1:0] uidx;
    logic [rtts_pkg::VAL_W-1:0] uval;
    logic [rtts_pkg::IDX_W-1:0] first;
    logic [rtts_pkg::IDX_W-1:0] last;
  } command_t;

  typedef struct packed {
    logic [rtts_pkg::SUM_W-1:0] pair_sum;
    logic                       status;
  } result_t;

  typedef struct packed {
    command_t cmd;
    logic     typed;
    result_t  res;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [rtts_pkg::IDX_W-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_opcode = rtts_pkg::OP_UPDATE;
  logic [rtts_pkg::IDX_W-1:0] in_update_index = '0;
  logic [rtts_pkg::VAL_W-1:0] in_update_value = '0;
  logic [rtts_pkg::IDX_W-1:0] in_range_first = '0;
  logic [rtts_pkg::IDX_W-1:0] in_range_last = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rtts_pkg::SUM_W-1:0] out_pair_sum;
  logic                       out_status;

  logic [rtts_pkg::VAL_W-1:0] entry_copy [DEPTH];
  int unsigned      length_copy = 32'(rtts_pkg::LEN_RESET);
  result_t          sums_due [$];
  row_t             stim_rows [$];
  result_t          popped;
  int unsigned      mismatches = 0;
  int unsigned      send_idle = 0;
  int unsigned      recv_stall = 0;
  int unsigned      hold_request = 0;
  int unsigned      hold_left = 0;
  int unsigned      hot_base = 1;
  int unsigned      cycle_count = 0;

  int unsigned ph_len   [PHASES] = '{2047, 1024, 2, 100, 1024, 37, 1024};
  int unsigned ph_send  [PHASES] = '{0, 72, 0, 29, 0, 72, 29};
  int unsigned ph_recv  [PHASES] = '{0, 0, 72, 29, 0, 72, 29};
  int unsigned ph_items [PHASES] = '{120, 150, 60, 150, 120, 100, 180};
  int unsigned ph_hold  [PHASES] = '{0, 0, 0, 0, 600, 0, 0};

  range_top_two_sum_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_update_index (in_update_index),
    .in_update_value (in_update_value),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pair_sum    (out_pair_sum),
    .out_status      (out_status)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("range_top_two_sum_table_unit_test: done, errors");
      $finish;
    end
  end

  function automatic int unsigned eff_len();
    return (length_copy > DEPTH) ? DEPTH : length_copy;
  endfunction

  function automatic result_t top_two_sum(input command_t c);
    result_t                    r;
    logic [rtts_pkg::VAL_W-1:0] top;
    logic [rtts_pkg::VAL_W-1:0] next;
    logic [rtts_pkg::VAL_W-1:0] v;
    int unsigned                i;
    top = '0;
    next = '0;
    if (c.first == 0 || c.last > eff_len() || c.first >= c.last) begin
      r.pair_sum = '0;
      r.status = rtts_pkg::STATUS_BAD;
      return r;
    end
    for (i = c.first - 1; i < c.last; i++) begin
      v = entry_copy[i];
      if (top < v) begin
        next = top;
        top = v;
      end else if (next < v) begin
        next = v;
      end
    end
    r.pair_sum = {1'b0, top} + {1'b0, next};
    r.status = rtts_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic row_t mk_row(input logic op, input int unsigned uidx,
                                  input int unsigned uval, input int unsigned first,
                                  input int unsigned last, input logic typed,
                                  input int unsigned sum, input logic status);
    row_t r;
    r.cmd.op = op;
    r.cmd.uidx = rtts_pkg::IDX_W'(uidx);
    r.cmd.uval = rtts_pkg::VAL_W'(uval);
    r.cmd.first = rtts_pkg::IDX_W'(first);
    r.cmd.last = rtts_pkg::IDX_W'(last);
    r.typed = typed;
    r.res.pair_sum = rtts_pkg::SUM_W'(sum);
    r.res.status = status;
    return r;
  endfunction

  // mostly well-formed commands around a hot window, some raw noise
  function automatic command_t make_cmd();
    command_t    c;
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    eff = eff_len();
    c.op = ($urandom_range(99) < 50) ? rtts_pkg::OP_QUERY : rtts_pkg::OP_UPDATE;
    c.uidx = rtts_pkg::IDX_W'($urandom);
    c.uval = rtts_pkg::VAL_W'($urandom);
    c.first = rtts_pkg::IDX_W'($urandom);
    c.last = rtts_pkg::IDX_W'($urandom);
    if (c.op == rtts_pkg::OP_UPDATE) begin
      if ($urandom_range(99) < 92) begin
        lo = ($urandom_range(1) == 0) ? 1 : hot_base;
        hi = (lo != 1 && lo + 63 < eff) ? lo + 63 : eff;
        c.uidx = rtts_pkg::IDX_W'($urandom_range(hi, lo));
      end
      if ($urandom_range(99) < 80) c.uval = rtts_pkg::VAL_W'($urandom_range(VALUE_LIMIT, 0));
    end else if ($urandom_range(99) < 88) begin
      lo = ($urandom_range(1) == 0) ? 1 : hot_base;
      hi = (lo != 1 && lo + 63 < eff - 1) ? lo + 63 : eff - 1;
      c.first = rtts_pkg::IDX_W'($urandom_range(hi, lo));
      span = ($urandom_range(99) < 70) ? $urandom_range(40, 1) : $urandom_range(eff, 1);
      c.last = rtts_pkg::IDX_W'((c.first + span > eff) ? eff : c.first + span);
    end
    return c;
  endfunction

  task automatic offer(input command_t c, input logic typed, input result_t fixed);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= c.op;
    in_update_index <= c.uidx;
    in_update_value <= c.uval;
    in_range_first <= c.first;
    in_range_last <= c.last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (c.op == rtts_pkg::OP_UPDATE) begin
      if (c.uidx >= 1 && c.uidx <= eff_len()) entry_copy[c.uidx - 1] = c.uval;
    end else begin
      sums_due.push_back(typed ? fixed : top_two_sum(c));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input int unsigned v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rtts_pkg::IDX_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_copy = v;
  endtask

  // result side: check each transfer, then choose next cycle's stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result: pair_sum %0d status %0d", out_pair_sum, out_status);
          mismatches++;
        end else begin
          popped = sums_due.pop_front();
          if (out_pair_sum !== popped.pair_sum) begin
            $error("pair_sum: expected %0d, got %0d", popped.pair_sum, out_pair_sum);
            mismatches++;
          end
          if (out_status !== popped.status) begin
            $error("status: expected %0d, got %0d", popped.status, out_status);
            mismatches++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall);
      end
    end
  end

  initial begin
    int unsigned r;
    foreach (entry_copy[i]) entry_copy[i] = '0;

    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 1024, 1'b1, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 0, 5, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 5, 5, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 10, 3, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 1025, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 2047, 2047, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 0, 2047, 1'b1, 0,
                               rtts_pkg::STATUS_BAD));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 0, 5, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 1025, 7, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 2047, VALUE_TOP, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 1024, 1'b1, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 1, VALUE_TOP, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 1024, VALUE_TOP, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 1024, 1'b1, SUM_TOP,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 2, 1'b1, VALUE_TOP,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1023, 1024, 1'b1, VALUE_TOP,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 32, VALUE_LIMIT, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 33, VALUE_LIMIT - 1, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 32, 33, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 2, 1023, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 64, VALUE_LIMIT, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 33, 96, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_UPDATE, 1, 0, 0, 0, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 31, 1'b0, 0,
                               rtts_pkg::STATUS_OK));
    stim_rows.push_back(mk_row(rtts_pkg::OP_QUERY, 0, 0, 1, 1024, 1'b0, 0,
                               rtts_pkg::STATUS_OK));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < stim_rows.size(); r++)
      offer(stim_rows[r].cmd, stim_rows[r].typed, stim_rows[r].res);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_length(ph_len[p]);
      send_idle = ph_send[p];
      recv_stall = ph_recv[p];
      hot_base = $urandom_range(eff_len() - 1, 1);
      hold_request = ph_hold[p];
      repeat (ph_items[p]) offer(make_cmd(), 1'b0, result_t'(0));
    end

    send_idle = 0;
    recv_stall = 0;
    drain();
    if (mismatches == 0) begin
      $display("range_top_two_sum_table_unit_test: done, clean");
    end else begin
      $display("range_top_two_sum_table_unit_test: done, errors");
    end
    $finish;
  end

endmodule
